### rtl/dda_step_pkg.sv
// Shared types and codes for the three-axis DDA step generator.
package dda_step_pkg;

    localparam int AXES = 3;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    // Per-axis update control, one copy per axis.
    typedef struct packed
    {
        logic load;
        logic tick;
        logic min_sw;
        logic max_sw;
    } axis_ctrl_t;

endpackage

### rtl/three_axis_dda_step_generator_top.sv
// Three-axis DDA step generator: input stage, three axis datapaths, result register.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid / in_ready | opcode, start_x/y/z, goal_x/y/z, min/max_switches
//  out     | out_valid/out_ready | step_mask, dir_mask, still_moving, pos_x/y/z
//
// One request per cycle sustained while out_ready stays high; a request passes
// the input register, then one add/compare/subtract per axis into the result
// register, before its result is valid. Async reset clears all axis state to
// zero and empties both stages. A stalled output holds the result and lets one
// more request into the input register before in_ready drops.
module three_axis_dda_step_generator_top #(
    parameter int POSITION_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            opcode,
    input  logic signed [POSITION_BITS-1:0] start_x,
    input  logic signed [POSITION_BITS-1:0] start_y,
    input  logic signed [POSITION_BITS-1:0] start_z,
    input  logic signed [POSITION_BITS-1:0] goal_x,
    input  logic signed [POSITION_BITS-1:0] goal_y,
    input  logic signed [POSITION_BITS-1:0] goal_z,
    input  logic [2:0]                      min_switches,
    input  logic [2:0]                      max_switches,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      step_mask,
    output logic [2:0]                      dir_mask,
    output logic                            still_moving,
    output logic signed [POSITION_BITS-1:0] pos_x,
    output logic signed [POSITION_BITS-1:0] pos_y,
    output logic signed [POSITION_BITS-1:0] pos_z
);
    import dda_step_pkg::*;

    localparam int W = POSITION_BITS;

    logic                s1_valid;
    opcode_t             s1_opcode;
    logic signed [W-1:0] s1_start [AXES];
    logic signed [W-1:0] s1_goal [AXES];
    logic [2:0]          s1_min_sw;
    logic [2:0]          s1_max_sw;
    logic                take;
    logic                fire;

    logic [W-1:0]        major_reg, major_next;
    logic [W-1:0]        major_load;
    logic [W-1:0]        major_sel;
    logic [W-1:0]        load_dist [AXES];
    logic [2:0]          step_vec;
    logic [2:0]          moving_vec;
    logic [2:0]          dir_vec;
    logic signed [W-1:0] pos_vec [AXES];
    axis_ctrl_t          ctrl [AXES];

    logic                out_valid_reg;
    logic [2:0]          step_reg;
    logic                moving_reg;

    assign take = !out_valid_reg || out_ready;
    assign fire = s1_valid && take;

    dda_step_in_stage #(
        .POSITION_BITS(W)
    ) u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .start_x     (start_x),
        .start_y     (start_y),
        .start_z     (start_z),
        .goal_x      (goal_x),
        .goal_y      (goal_y),
        .goal_z      (goal_z),
        .min_switches(min_switches),
        .max_switches(max_switches),
        .take        (take),
        .s1_valid    (s1_valid),
        .s1_opcode   (s1_opcode),
        .s1_start    (s1_start),
        .s1_goal     (s1_goal),
        .s1_min_sw   (s1_min_sw),
        .s1_max_sw   (s1_max_sw)
    );

    // Largest distance of a new move.
    always_comb
    begin
        major_load = load_dist[0];
        if (load_dist[1] > major_load)
        begin
            major_load = load_dist[1];
        end
        if (load_dist[2] > major_load)
        begin
            major_load = load_dist[2];
        end
    end

    assign major_sel  = (s1_opcode == OP_LOAD) ? major_load : major_reg;
    assign major_next = (fire && s1_opcode == OP_LOAD) ? major_load : major_reg;

    for (genvar a = 0; a < AXES; a++)
    begin : g_axis
        assign ctrl[a].load   = fire && (s1_opcode == OP_LOAD);
        assign ctrl[a].tick   = fire && (s1_opcode == OP_TICK);
        assign ctrl[a].min_sw = s1_min_sw[a];
        assign ctrl[a].max_sw = s1_max_sw[a];

        dda_step_axis #(
            .POSITION_BITS(W)
        ) u_axis (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl[a]),
            .start    (s1_start[a]),
            .goal     (s1_goal[a]),
            .major    (major_sel),
            .load_dist(load_dist[a]),
            .step     (step_vec[a]),
            .moving   (moving_vec[a]),
            .dir      (dir_vec[a]),
            .pos      (pos_vec[a])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            major_reg <= major_next;
            if (take)
            begin
                out_valid_reg <= s1_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            step_reg   <= step_vec;
            moving_reg <= |moving_vec;
        end
    end

    // Axis state only changes when a result is written here, so positions and
    // directions read straight from it match the held result.
    assign out_valid    = out_valid_reg;
    assign step_mask    = step_reg;
    assign still_moving = moving_reg;
    assign dir_mask     = dir_vec;
    assign pos_x        = pos_vec[0];
    assign pos_y        = pos_vec[1];
    assign pos_z        = pos_vec[2];

endmodule

### rtl/dda_step_in_stage.sv
// Input register stage: holds one request until the datapath takes it.
module dda_step_in_stage #(
    parameter int POSITION_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            opcode,
    input  logic signed [POSITION_BITS-1:0] start_x,
    input  logic signed [POSITION_BITS-1:0] start_y,
    input  logic signed [POSITION_BITS-1:0] start_z,
    input  logic signed [POSITION_BITS-1:0] goal_x,
    input  logic signed [POSITION_BITS-1:0] goal_y,
    input  logic signed [POSITION_BITS-1:0] goal_z,
    input  logic [2:0]                      min_switches,
    input  logic [2:0]                      max_switches,
    input  logic                            take,
    output logic                            s1_valid,
    output dda_step_pkg::opcode_t           s1_opcode,
    output logic signed [POSITION_BITS-1:0] s1_start [3],
    output logic signed [POSITION_BITS-1:0] s1_goal [3],
    output logic [2:0]                      s1_min_sw,
    output logic [2:0]                      s1_max_sw
);
    import dda_step_pkg::*;

    logic                            valid_reg;
    opcode_t                         opcode_reg;
    logic signed [POSITION_BITS-1:0] start_reg [3];
    logic signed [POSITION_BITS-1:0] goal_reg [3];
    logic [2:0]                      min_reg;
    logic [2:0]                      max_reg;
    logic                            load_en;

    assign in_ready = !valid_reg || take;
    assign load_en  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            opcode_reg   <= opcode_t'(opcode);
            start_reg[0] <= start_x;
            start_reg[1] <= start_y;
            start_reg[2] <= start_z;
            goal_reg[0]  <= goal_x;
            goal_reg[1]  <= goal_y;
            goal_reg[2]  <= goal_z;
            min_reg      <= min_switches;
            max_reg      <= max_switches;
        end
    end

    assign s1_valid  = valid_reg;
    assign s1_opcode = opcode_reg;
    assign s1_start  = start_reg;
    assign s1_goal   = goal_reg;
    assign s1_min_sw = min_reg;
    assign s1_max_sw = max_reg;

endmodule

### rtl/dda_step_axis.sv
// One axis of the DDA: position, target, distance, direction and error term.
module dda_step_axis #(
    parameter int POSITION_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dda_step_pkg::axis_ctrl_t        ctrl,
    input  logic signed [POSITION_BITS-1:0] start,
    input  logic signed [POSITION_BITS-1:0] goal,
    input  logic [POSITION_BITS-1:0]        major,
    output logic [POSITION_BITS-1:0]        load_dist,
    output logic                            step,
    output logic                            moving,
    output logic                            dir,
    output logic signed [POSITION_BITS-1:0] pos
);
    import dda_step_pkg::*;

    localparam int W = POSITION_BITS;

    logic signed [W-1:0] cur_reg, cur_next;
    logic signed [W-1:0] tgt_reg, tgt_next;
    logic [W-1:0]        dist_reg, dist_next;
    logic signed [W:0]   acc_reg, acc_next;
    logic                dir_reg, dir_next;

    logic signed [W:0]   diff;
    logic [W:0]          diff_neg;
    logic                load_up;
    logic [W+1:0]        acc_load_wide;
    logic signed [W+1:0] sum;
    logic signed [W+1:0] sum_less_major;
    logic                blocked;
    logic                allowed;
    logic                fire_step;

    // Load: distance and direction from start and goal.
    assign diff      = {goal[W-1], goal} - {start[W-1], start};
    assign diff_neg  = '0 - diff;
    assign load_up   = !diff[W];
    assign load_dist = load_up ? diff[W-1:0] : diff_neg[W-1:0];
    assign acc_load_wide = '0 - {3'b000, major[W-1:1]};

    // Tick: permission, accumulate, step on positive error.
    assign blocked   = (ctrl.min_sw && !dir_reg) || (ctrl.max_sw && dir_reg);
    assign allowed   = (cur_reg != tgt_reg) && !blocked;
    assign sum       = {acc_reg[W], acc_reg} + $signed({2'b00, dist_reg});
    assign sum_less_major = sum - $signed({2'b00, major});
    assign fire_step = allowed && !sum[W+1] && (sum != '0);

    always_comb
    begin
        cur_next  = cur_reg;
        tgt_next  = tgt_reg;
        dist_next = dist_reg;
        acc_next  = acc_reg;
        dir_next  = dir_reg;
        if (ctrl.load)
        begin
            cur_next  = start;
            tgt_next  = goal;
            dist_next = load_dist;
            acc_next  = acc_load_wide[W:0];
            dir_next  = load_up;
        end
        else if (ctrl.tick && allowed)
        begin
            if (fire_step)
            begin
                acc_next = sum_less_major[W:0];
                cur_next = dir_reg ? cur_reg + W'(1) : cur_reg - W'(1);
            end
            else
            begin
                acc_next = sum[W:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg  <= '0;
            tgt_reg  <= '0;
            dist_reg <= '0;
            acc_reg  <= '0;
            dir_reg  <= 1'b0;
        end
        else
        begin
            cur_reg  <= cur_next;
            tgt_reg  <= tgt_next;
            dist_reg <= dist_next;
            acc_reg  <= acc_next;
            dir_reg  <= dir_next;
        end
    end

    assign step   = ctrl.tick && fire_step;
    assign moving = ctrl.load ? (load_dist != '0) : (ctrl.tick && allowed);
    assign dir    = dir_reg;
    assign pos    = cur_reg;

endmodule

### rtl/dda_step_chk.sv
// Port-level checks for the step generator, bound to the top level.
module dda_step_chk #(
    parameter int POSITION_BITS = 24
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [2:0]                      step_mask,
    input logic [2:0]                      dir_mask,
    input logic                            still_moving,
    input logic signed [POSITION_BITS-1:0] pos_x,
    input logic signed [POSITION_BITS-1:0] pos_y,
    input logic signed [POSITION_BITS-1:0] pos_z
);

    // No result may appear right out of reset.
    a_idle_after_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid right after reset");

    // A pulse on any axis means the move was live on that request.
    a_step_needs_moving: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (step_mask != 3'b000) |-> still_moving)
        else $error("step pulse with move finished");

    // Stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(step_mask)
            && $stable(dir_mask) && $stable(still_moving)
            && $stable(pos_x) && $stable(pos_y) && $stable(pos_z))
        else $error("stalled result changed");

    // Only one request is buffered behind a stalled result.
    a_one_deep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && in_valid && in_ready
            ##1 out_valid && !out_ready |-> !in_ready)
        else $error("more than one request buffered behind stall");

endmodule

bind three_axis_dda_step_generator_top dda_step_chk #(
    .POSITION_BITS(POSITION_BITS)
) u_dda_step_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .step_mask   (step_mask),
    .dir_mask    (dir_mask),
    .still_moving(still_moving),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z)
);

### verif/dda_step_checker.sv
// Checker for the DDA step generator: predicts each result from accepted requests and compares.
`timescale 1ns / 100ps
module dda_step_checker #(
    parameter int POSITION_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            opcode,
    input  logic signed [POSITION_BITS-1:0] start_x,
    input  logic signed [POSITION_BITS-1:0] start_y,
    input  logic signed [POSITION_BITS-1:0] start_z,
    input  logic signed [POSITION_BITS-1:0] goal_x,
    input  logic signed [POSITION_BITS-1:0] goal_y,
    input  logic signed [POSITION_BITS-1:0] goal_z,
    input  logic [2:0]                      min_switches,
    input  logic [2:0]                      max_switches,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [2:0]                      step_mask,
    input  logic [2:0]                      dir_mask,
    input  logic                            still_moving,
    input  logic signed [POSITION_BITS-1:0] pos_x,
    input  logic signed [POSITION_BITS-1:0] pos_y,
    input  logic signed [POSITION_BITS-1:0] pos_z,
    output int                              pending,
    output int                              mismatches,
    output int                              results_seen,
    output int                              pulses_seen
);
    import dda_step_pkg::*;

    localparam int PB = POSITION_BITS;

    typedef struct packed
    {
        logic [2:0]    steps;
        logic [2:0]    dirs;
        logic          moving;
        logic [PB-1:0] px;
        logic [PB-1:0] py;
        logic [PB-1:0] pz;
    } motion_result_t;

    // Predicted machine state
    logic signed [PB-1:0] cur_pos [AXES];
    logic signed [PB-1:0] goal_pos [AXES];
    logic [PB-1:0]        travel [AXES];
    logic signed [PB:0]   err_acc [AXES];
    logic [2:0]           up_dir;
    logic [PB-1:0]        major_travel;

    motion_result_t motion_q [$];

    function automatic motion_result_t predict_motion(
        input logic          op,
        input logic [3*PB-1:0] starts,
        input logic [3*PB-1:0] goals,
        input logic [2:0]    mins,
        input logic [2:0]    maxs
    );
        motion_result_t       r;
        logic signed [PB-1:0] s;
        logic signed [PB-1:0] g;
        logic signed [PB:0]   diff;
        logic [PB-1:0]        major;
        logic                 allowed;
        int                   a;
        r = '0;
        if (op == OP_LOAD)
        begin
            major = '0;
            up_dir = '0;
            for (a = 0; a < AXES; a++)
            begin
                s = starts[a*PB +: PB];
                g = goals[a*PB +: PB];
                cur_pos[a] = s;
                goal_pos[a] = g;
                diff = {g[PB-1], g} - {s[PB-1], s};
                if (diff < 0)
                    diff = -diff;
                travel[a] = diff[PB-1:0];
                if (g >= s)
                    up_dir[a] = 1'b1;
                if (travel[a] > major)
                    major = travel[a];
                if (travel[a] != '0)
                    r.moving = 1'b1;
            end
            major_travel = major;
            // accumulators start at minus half the major distance, rounded down
            for (a = 0; a < AXES; a++)
                err_acc[a] = -$signed({2'b00, major[PB-1:1]});
        end
        else
        begin
            for (a = 0; a < AXES; a++)
            begin
                // only the switch on the travel side blocks an axis
                allowed = (cur_pos[a] != goal_pos[a])
                          && !(mins[a] && !up_dir[a])
                          && !(maxs[a] && up_dir[a]);
                if (allowed)
                begin
                    r.moving = 1'b1;
                    err_acc[a] = err_acc[a] + $signed({1'b0, travel[a]});
                    if (err_acc[a] > 0)
                    begin
                        r.steps[a] = 1'b1;
                        err_acc[a] = err_acc[a] - $signed({1'b0, major_travel});
                        cur_pos[a] = up_dir[a] ? cur_pos[a] + PB'(1) : cur_pos[a] - PB'(1);
                    end
                end
            end
        end
        r.dirs = up_dir;
        r.px = cur_pos[0];
        r.py = cur_pos[1];
        r.pz = cur_pos[2];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [PB-1:0] got,
                                   input logic [PB-1:0] want);
        $display("[%0t] %s mismatch on result %0d: got 'h%0h, expected 'h%0h",
                 $time, field, results_seen, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        motion_result_t want;
        int             a;
        if (!rst_n)
        begin
            for (a = 0; a < AXES; a++)
            begin
                cur_pos[a] = '0;
                goal_pos[a] = '0;
                travel[a] = '0;
                err_acc[a] = '0;
            end
            up_dir = '0;
            major_travel = '0;
            motion_q.delete();
            pending = 0;
            mismatches = 0;
            results_seen = 0;
            pulses_seen = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                pulses_seen += $countones(step_mask);
                if (motion_q.size() == 0)
                    report_mismatch("result with no request outstanding", '0, '0);
                else
                begin
                    want = motion_q.pop_front();
                    if (step_mask !== want.steps)
                        report_mismatch("step_mask", PB'(step_mask), PB'(want.steps));
                    if (dir_mask !== want.dirs)
                        report_mismatch("dir_mask", PB'(dir_mask), PB'(want.dirs));
                    if (still_moving !== want.moving)
                        report_mismatch("still_moving", PB'(still_moving),
                                        PB'(want.moving));
                    if (pos_x !== want.px)
                        report_mismatch("pos_x", pos_x, want.px);
                    if (pos_y !== want.py)
                        report_mismatch("pos_y", pos_y, want.py);
                    if (pos_z !== want.pz)
                        report_mismatch("pos_z", pos_z, want.pz);
                end
            end
            if (in_valid && in_ready)
                motion_q.push_back(predict_motion(opcode, {start_z, start_y, start_x},
                                                  {goal_z, goal_y, goal_x},
                                                  min_switches, max_switches));
            pending = motion_q.size();
        end
    end

endmodule

### verif/testbench.sv
// Top of the DDA step generator testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
    import dda_step_pkg::*;

    localparam int PB = 24;
    localparam int REQUEST_TARGET = 1850;
    localparam int POS_MAX = 8388607;
    localparam int POS_MIN = -8388608;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic          opcode = OP_LOAD;
    logic [PB-1:0] start_x = '0;
    logic [PB-1:0] start_y = '0;
    logic [PB-1:0] start_z = '0;
    logic [PB-1:0] goal_x = '0;
    logic [PB-1:0] goal_y = '0;
    logic [PB-1:0] goal_z = '0;
    logic [2:0]    min_switches = '0;
    logic [2:0]    max_switches = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [2:0]    step_mask;
    logic [2:0]    dir_mask;
    logic          still_moving;
    logic [PB-1:0] pos_x;
    logic [PB-1:0] pos_y;
    logic [PB-1:0] pos_z;

    int pending;
    int mismatches;
    int results_seen;
    int pulses_seen;

    int burst_left = 0;
    int requests_sent = 0;
    int loads_sent = 0;
    int ticks_sent = 0;
    int hold_off_requests = 0;

    three_axis_dda_step_generator_top #(.POSITION_BITS(PB)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
        .start_x(start_x), .start_y(start_y), .start_z(start_z),
        .goal_x(goal_x), .goal_y(goal_y), .goal_z(goal_z),
        .min_switches(min_switches), .max_switches(max_switches),
        .out_valid(out_valid), .out_ready(out_ready),
        .step_mask(step_mask), .dir_mask(dir_mask), .still_moving(still_moving),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z)
    );

    dda_step_checker #(.POSITION_BITS(PB)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
        .start_x(start_x), .start_y(start_y), .start_z(start_z),
        .goal_x(goal_x), .goal_y(goal_y), .goal_z(goal_z),
        .min_switches(min_switches), .max_switches(max_switches),
        .out_valid(out_valid), .out_ready(out_ready),
        .step_mask(step_mask), .dir_mask(dir_mask), .still_moving(still_moving),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .pending(pending), .mismatches(mismatches),
        .results_seen(results_seen), .pulses_seen(pulses_seen)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Run timed out with %0d results outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // Output side: decisions at the falling edge, driven at the rising edge
    initial
    begin : receiver
        int  holds_done;
        int  stall_left;
        int  mode;
        int  mode_left;
        int  phase;
        logic next_ready;
        holds_done = 0;
        stall_left = 0;
        mode = 0;
        mode_left = 0;
        phase = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_requests != holds_done)
            begin
                holds_done++;
                stall_left = $urandom_range(150, 250);
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            phase++;
            if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else
            begin
                case (mode)
                    0: next_ready = 1'b1;
                    1: next_ready = $urandom_range(0, 3) != 0;
                    2: next_ready = $urandom_range(0, 3) == 0;
                    default: next_ready = (phase % 3) != 0;
                endcase
            end
            @(posedge clk);
            out_ready <= next_ready;
        end
    end

    task automatic offer_request(input logic op,
                                 input logic [PB-1:0] sx, input logic [PB-1:0] sy,
                                 input logic [PB-1:0] sz, input logic [PB-1:0] gx,
                                 input logic [PB-1:0] gy, input logic [PB-1:0] gz,
                                 input logic [2:0] mins, input logic [2:0] maxs);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(60, 150);
            else
                burst_left = $urandom_range(1, 24);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        start_x <= sx;
        start_y <= sy;
        start_z <= sz;
        goal_x <= gx;
        goal_y <= gy;
        goal_z <= gz;
        min_switches <= mins;
        max_switches <= maxs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        requests_sent++;
        if (op == OP_LOAD)
            loads_sent++;
        else
            ticks_sent++;
    endtask

    // Unused position fields carry random noise on ticks, switches carry noise on loads
    task automatic send_tick(input logic [2:0] mins, input logic [2:0] maxs);
        offer_request(OP_TICK, PB'($urandom), PB'($urandom), PB'($urandom),
                      PB'($urandom), PB'($urandom), PB'($urandom), mins, maxs);
    endtask

    task automatic send_load(input int sx, input int sy, input int sz,
                             input int gx, input int gy, input int gz);
        offer_request(OP_LOAD, PB'(sx), PB'(sy), PB'(sz), PB'(gx), PB'(gy), PB'(gz),
                      3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // A load with short per-axis travel, then enough ticks to finish it (mostly)
    task automatic run_move(input int reach);
        int            s [3];
        int            g [3];
        int            delta;
        int            sgn;
        int            longest;
        int            n;
        int            a;
        logic [PB-1:0] raw;
        longest = 0;
        for (a = 0; a < 3; a++)
        begin
            case ($urandom_range(0, 3))
                0: s[a] = POS_MAX - $urandom_range(0, 30);
                1: s[a] = POS_MIN + $urandom_range(0, 30);
                default:
                begin
                    raw = PB'($urandom);
                    s[a] = int'($signed(raw));
                end
            endcase
            delta = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, reach);
            sgn = $urandom_range(0, 1) ? 1 : -1;
            g[a] = s[a] + sgn * delta;
            if (g[a] > POS_MAX || g[a] < POS_MIN)
                g[a] = s[a] - sgn * delta;
            if (delta > longest)
                longest = delta;
        end
        send_load(s[0], s[1], s[2], g[0], g[1], g[2]);
        n = longest + $urandom_range(0, 4);
        // now and then a new move cuts in before this one finishes
        if (longest > 1 && $urandom_range(0, 9) == 0)
            n = $urandom_range(1, longest - 1);
        repeat (n)
        begin
            if ($urandom_range(0, 4) == 0)
                send_tick(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            else
                send_tick(3'b000, 3'b000);
        end
    endtask

    initial
    begin : stimulus
        int  pick;
        int  drain_cycles;
        bit  first_hold;
        bit  second_hold;
        bit  mid_drain;
        first_hold = 1'b0;
        second_hold = 1'b0;
        mid_drain = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ticks with nothing loaded
        send_tick(3'b000, 3'b000);
        send_tick(3'b111, 3'b111);
        // full-scale travel: X up, Y down, Z idle
        send_load(POS_MIN, POS_MAX, 0, POS_MAX, POS_MIN, 0);
        send_tick(3'b000, 3'b000);
        send_tick(3'b111, 3'b000);
        send_tick(3'b000, 3'b111);
        send_tick(3'b111, 3'b111);
        // zero-length move at the extremes
        send_load(POS_MAX, POS_MIN, 0, POS_MAX, POS_MIN, 0);
        send_tick(3'b000, 3'b000);
        // short move, ticked past its end
        send_load(10, -5, 100, 13, -12, 100);
        repeat (9) send_tick(3'b000, 3'b000);
        // switches on the far side are ignored, on the travel side they block
        send_load(-1, 0, 5, 2, -4, -3);
        send_tick(3'b001, 3'b000);
        send_tick(3'b000, 3'b110);
        send_tick(3'b110, 3'b001);
        wait_for_results();

        while (requests_sent < REQUEST_TARGET)
        begin
            if (!first_hold && requests_sent > 500)
            begin
                first_hold = 1'b1;
                hold_off_requests++;
            end
            if (!mid_drain && requests_sent > 1000)
            begin
                mid_drain = 1'b1;
                wait_for_results();
            end
            if (!second_hold && requests_sent > 1300)
            begin
                second_hold = 1'b1;
                hold_off_requests++;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
                run_move(120);
            else if (pick < 72)
                run_move(24);
            else if (pick < 85)
            begin
                send_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                repeat ($urandom_range(1, 6))
                    send_tick(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    offer_request($urandom_range(0, 1) ? OP_TICK : OP_LOAD,
                                  PB'($urandom), PB'($urandom), PB'($urandom),
                                  PB'($urandom), PB'($urandom), PB'($urandom),
                                  3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            end
        end

        in_valid <= 1'b0;
        @(negedge clk);
        drain_cycles = 0;
        while (pending != 0 && drain_cycles < 50000)
        begin
            @(negedge clk);
            drain_cycles++;
        end
        repeat (10) @(negedge clk);
        if (pending != 0)
            $display("%0d results never arrived", pending);
        $display("Run covered %0d loads and %0d ticks: extreme positions, travel-side",
                 loads_sent, ticks_sent);
        $display("and far-side switches, %0d results with %0d step pulses, long output stalls.",
                 results_seen, pulses_seen);
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
